FILE: rtl/rhc_pkg.sv
// Package with the request and result types and codes of the handle cache.
`timescale 1ns / 1ps

package rhc_pkg;

  // Field widths fixed by the interface.
  localparam int ACTION_W = 2;
  localparam int KEY_W    = 16;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;

  // Request actions.
  localparam logic [ACTION_W-1:0] ACT_GET    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUT    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOCK   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNLOCK = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_BUSY   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_PUT_ZERO   = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [SLOT_W-1:0]   slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_out;
    logic                hit;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

FILE: rtl/rhc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module rhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/refcounted_handle_cache.sv
// Top level of the reference-counted handle cache.
//
// A request (action, key, slot) is accepted at a rising edge where start is
// high and busy is low. Every request gives exactly one result, shown on the
// result port for one cycle while done is high; the receiver cannot stall it.
// Get scans the slot table one entry per cycle through the RAM's registered
// read port; a hit ends the scan early. Put, lock and unlock read the
// addressed entry, modify it and write it back, raising done as the write
// is made. Busy is low again in the cycle done is shown, so the next request
// may be taken then.
// The table lives in one RAM holding key, count and busy mark per slot; a
// valid bit per slot, cleared by reset, makes an unwritten slot read as zero,
// so the block is ready in the first cycle after reset with no clearing pass.
// Reset drops any request in flight and clears done and busy.
`timescale 1ns / 1ps

module refcounted_handle_cache #(
  parameter int SLOTS      = 16,
  parameter int KEY_BITS   = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  rhc_pkg::req_t request,
  output logic         done,
  output rhc_pkg::rsp_t result
);
  import rhc_pkg::*;

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int ENTRY_W = KEY_BITS + COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
  localparam logic [IDX_W-1:0]      LAST_IDX   = IDX_W'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OP   = 2'd2;

  // Control registers.
  logic [1:0]       state, state_next;
  logic [SLOTS-1:0] valid;
  logic             rd_valid;
  logic [IDX_W-1:0] scan_addr, scan_addr_next;
  logic             issued_all, issued_all_next;
  logic [IDX_W-1:0] chk_addr, chk_addr_next;
  logic             chk_en, chk_en_next;
  logic             have_free, have_free_next;
  logic [IDX_W-1:0] free_slot, free_slot_next;
  logic             done_next;

  // Payload registers.
  req_t                op;
  logic [KEY_BITS-1:0] op_key;
  rsp_t                result_next;

  // RAM ports.
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [ENTRY_W-1:0]  wdata;
  logic                re;
  logic [IDX_W-1:0]    raddr;
  logic [ENTRY_W-1:0]  rdata;

  // Decoded entry as read.
  logic [KEY_BITS-1:0]   e_key;
  logic [COUNT_BITS-1:0] e_count;
  logic                  e_busy;

  logic                  accept;
  logic [KEY_BITS-1:0]   in_key;
  logic                  in_range;
  logic                  op_in_range;

  rhc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign accept   = start && !busy;
  assign busy     = (state != ST_IDLE);
  assign in_key   = KEY_BITS'(32'(request.key));
  assign in_range = (32'(request.slot) < SLOTS);
  assign op_in_range = (32'(op.slot) < SLOTS);

  // A slot never written reads as all zero.
  assign {e_key, e_count, e_busy} = rd_valid ? rdata : '0;

  // Sequencing of the scan and the read-modify-write.
  always_comb begin
    state_next      = state;
    scan_addr_next  = scan_addr;
    issued_all_next = issued_all;
    chk_addr_next   = chk_addr;
    chk_en_next     = chk_en;
    have_free_next  = have_free;
    free_slot_next  = free_slot;
    done_next       = 1'b0;
    result_next     = '{slot_out: op.slot, hit: 1'b0, status: STAT_OK};
    we              = 1'b0;
    waddr           = chk_addr;
    wdata           = {e_key, e_count, e_busy};
    re              = 1'b0;
    raddr           = scan_addr;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (request.action == ACT_GET) begin
            state_next      = ST_SCAN;
            scan_addr_next  = '0;
            issued_all_next = 1'b0;
            chk_en_next     = 1'b0;
            have_free_next  = 1'b0;
          end else begin
            state_next = ST_OP;
            re         = in_range;
            raddr      = IDX_W'(32'(request.slot));
          end
        end
      end

      ST_SCAN: begin
        // Check the entry read last cycle.
        if (chk_en && e_count == '0) begin
          have_free_next = 1'b1;
          free_slot_next = chk_addr;
        end
        if (chk_en && e_count != '0 && e_key == op_key) begin
          // Hit: bump the count, saturating.
          we          = 1'b1;
          waddr       = chk_addr;
          wdata       = {e_key, (e_count == COUNT_MAX) ? e_count : e_count + COUNT_ONE,
                         e_busy};
          done_next   = 1'b1;
          result_next = '{slot_out: SLOT_W'(32'(chk_addr)), hit: 1'b1, status: STAT_OK};
          chk_en_next = 1'b0;
          state_next  = ST_IDLE;
        end else if (!issued_all) begin
          // Issue the next read.
          re            = 1'b1;
          raddr         = scan_addr;
          chk_addr_next = scan_addr;
          chk_en_next   = 1'b1;
          if (scan_addr == LAST_IDX) begin
            issued_all_next = 1'b1;
          end else begin
            scan_addr_next = scan_addr + IDX_W'(1);
          end
        end else begin
          // Miss after the whole table: claim the highest free slot.
          chk_en_next = 1'b0;
          state_next  = ST_IDLE;
          done_next   = 1'b1;
          if (have_free_next) begin
            we          = 1'b1;
            waddr       = free_slot_next;
            wdata       = {op_key, COUNT_ONE, 1'b0};
            result_next = '{slot_out: SLOT_W'(32'(free_slot_next)), hit: 1'b0,
                            status: STAT_OK};
          end else begin
            result_next = '{slot_out: op.slot, hit: 1'b0, status: STAT_FULL};
          end
        end
      end

      ST_OP: begin
        // Modify the addressed entry and write it back.
        state_next = ST_IDLE;
        done_next  = 1'b1;
        waddr      = IDX_W'(32'(op.slot));
        if (op_in_range) begin
          case (op.action)
            ACT_PUT: begin
              if (e_count == '0) begin
                result_next.status = STAT_PUT_ZERO;
              end else begin
                we    = 1'b1;
                wdata = {e_key, e_count - COUNT_ONE, e_busy};
              end
            end
            ACT_LOCK: begin
              we    = 1'b1;
              wdata = {e_key, e_count, 1'b1};
            end
            ACT_UNLOCK: begin
              if (!e_busy) begin
                result_next.status = STAT_NOT_BUSY;
              end else begin
                we    = 1'b1;
                wdata = {e_key, e_count, 1'b0};
              end
            end
            default: begin
              result_next.status = STAT_OK;
            end
          endcase
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      rd_valid   <= 1'b0;
      scan_addr  <= '0;
      issued_all <= 1'b0;
      chk_addr   <= '0;
      chk_en     <= 1'b0;
      have_free  <= 1'b0;
      free_slot  <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      scan_addr  <= scan_addr_next;
      issued_all <= issued_all_next;
      chk_addr   <= chk_addr_next;
      chk_en     <= chk_en_next;
      have_free  <= have_free_next;
      free_slot  <= free_slot_next;
      done       <= done_next;
      if (re) begin
        rd_valid <= valid[raddr];
      end
      if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= request;
      op_key <= in_key;
    end
    result <= result_next;
  end

endmodule

FILE: tb/refcounted_handle_cache_test.sv
// Testbench for the reference-counted handle cache: directed table, random sequences, predictor.
`timescale 1ns / 1ps

module refcounted_handle_cache_test;
  import rhc_pkg::*;

  localparam int SLOTS       = 16;
  localparam logic [7:0] COUNT_TOP = 8'hFF;
  localparam int ITEMS       = 950;
  localparam int CALM_ITEMS  = 100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 24;

  // One row of the directed table; want is used only where typed is set.
  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic done;
  rsp_t result;

  // Typed expectation for the request now on the port.
  bit   cur_typed = 1'b0;
  rsp_t cur_want = '0;

  // Predicted table contents.
  logic [15:0] cached_key  [SLOTS] = '{default: '0};
  logic [7:0]  cached_refs [SLOTS] = '{default: '0};
  logic        cached_busy [SLOTS] = '{default: 1'b0};

  rsp_t     due_results[$];
  dir_row_t dir_rows[$];
  int       accepted_cnt = 0;
  int       items_sent = 0;
  int       errors = 0;
  int       cycles = 0;
  bit       idle_on = 1'b1;
  logic [15:0] key_pool[8];
  rsp_t     oldest;
  rsp_t     predicted;

  refcounted_handle_cache u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // Apply one request to the predicted table and return its result.
  function automatic rsp_t predict_handle(req_t rq);
    rsp_t r;
    bit have_free;
    bit found;
    logic [3:0] free_idx;
    r.slot_out = rq.slot;
    r.hit = 1'b0;
    r.status = STAT_OK;
    if (rq.action == ACT_GET) begin
      have_free = 1'b0;
      found = 1'b0;
      free_idx = '0;
      // Lowest referenced match wins; the last free slot seen is the highest.
      for (int i = 0; i < SLOTS; i++) begin
        if (!found) begin
          if (cached_refs[i] == '0) begin
            have_free = 1'b1;
            free_idx = 4'(i);
          end else if (cached_key[i] == rq.key) begin
            found = 1'b1;
            if (cached_refs[i] != COUNT_TOP) cached_refs[i] = cached_refs[i] + 8'd1;
            r.slot_out = 4'(i);
            r.hit = 1'b1;
          end
        end
      end
      if (!found) begin
        if (!have_free) begin
          r.status = STAT_FULL;
        end else begin
          cached_key[free_idx] = rq.key;
          cached_refs[free_idx] = 8'd1;
          cached_busy[free_idx] = 1'b0;
          r.slot_out = free_idx;
        end
      end
    end else if (rq.action == ACT_PUT) begin
      if (cached_refs[rq.slot] == '0) r.status = STAT_PUT_ZERO;
      else cached_refs[rq.slot] = cached_refs[rq.slot] - 8'd1;
    end else if (rq.action == ACT_LOCK) begin
      cached_busy[rq.slot] = 1'b1;
    end else begin
      if (!cached_busy[rq.slot]) r.status = STAT_NOT_BUSY;
      else cached_busy[rq.slot] = 1'b0;
    end
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic [1:0] act, logic [15:0] k, logic [3:0] s,
                                       bit typed, logic [3:0] so, logic h, logic [1:0] st);
    dir_row_t d;
    d.rq.action = act;
    d.rq.key = k;
    d.rq.slot = s;
    d.typed = typed;
    d.want.slot_out = so;
    d.want.hit = h;
    d.want.status = st;
    return d;
  endfunction

  // Check results against the oldest expectation and record accepted requests.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                   $time, result.slot_out, result.hit, result.status);
        end else begin
          oldest = due_results.pop_front();
          if (result.slot_out !== oldest.slot_out || result.hit !== oldest.hit ||
              result.status !== oldest.status) begin
            errors++;
            $display("%0t: expected slot_out/hit/status %0d/%0d/%0d, actual %0d/%0d/%0d",
                     $time, oldest.slot_out, oldest.hit, oldest.status,
                     result.slot_out, result.hit, result.status);
          end
        end
      end
      if (start && !busy) begin
        predicted = predict_handle(request);
        due_results.push_back(cur_typed ? cur_want : predicted);
        accepted_cnt++;
      end
    end
  end

  // Cycle counter that ends a hung run.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Present one request from a falling edge and hold it until it is taken.
  task automatic send(req_t rq, bit typed, rsp_t want);
    int target;
    target = accepted_cnt + 1;
    start <= 1'b1;
    request <= rq;
    cur_typed <= typed;
    cur_want <= want;
    do @(negedge clk); while (accepted_cnt < target);
    items_sent++;
  endtask

  // Random sender gap, none in the closing stretch of the run.
  task automatic maybe_idle();
    int n;
    if (idle_on && items_sent < ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_rand(logic [1:0] act, logic [15:0] k, logic [3:0] s);
    req_t rq;
    rq.action = act;
    rq.key = k;
    rq.slot = s;
    maybe_idle();
    send(rq, 1'b0, '0);
  endtask

  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 65535));
    return key_pool[3'($urandom_range(0, 7))];
  endfunction

  // Many gets of one key, enough to drive its count to saturation.
  task automatic hammer_key();
    logic [15:0] k;
    k = pick_key();
    repeat (270) send_rand(ACT_GET, k, 4'($urandom_range(0, 15)));
  endtask

  initial begin
    int hammers;
    int pick;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = 16'($urandom_range(0, 65535));

    // Directed table: typed rows are the ones readable straight from an empty table.
    dir_rows.push_back(dir_row(ACT_PUT,    16'h0000, 4'd3,  1'b1, 4'd3,  1'b0, STAT_PUT_ZERO));
    dir_rows.push_back(dir_row(ACT_UNLOCK, 16'h0000, 4'd0,  1'b1, 4'd0,  1'b0, STAT_NOT_BUSY));
    dir_rows.push_back(dir_row(ACT_LOCK,   16'h0000, 4'd0,  1'b1, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_LOCK,   16'hFFFF, 4'd0,  1'b1, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_UNLOCK, 16'h0000, 4'd0,  1'b1, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_UNLOCK, 16'h0000, 4'd0,  1'b1, 4'd0,  1'b0, STAT_NOT_BUSY));
    dir_rows.push_back(dir_row(ACT_GET,    16'hFFFF, 4'd0,  1'b1, 4'd15, 1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_GET,    16'hFFFF, 4'd9,  1'b1, 4'd15, 1'b1, STAT_OK));
    dir_rows.push_back(dir_row(ACT_GET,    16'h0000, 4'd15, 1'b1, 4'd14, 1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_GET,    16'h0000, 4'd0,  1'b1, 4'd14, 1'b1, STAT_OK));
    dir_rows.push_back(dir_row(ACT_PUT,    16'h0000, 4'd15, 1'b1, 4'd15, 1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_PUT,    16'hFFFF, 4'd15, 1'b1, 4'd15, 1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_PUT,    16'h0000, 4'd15, 1'b1, 4'd15, 1'b0, STAT_PUT_ZERO));
    dir_rows.push_back(dir_row(ACT_GET,    16'h8000, 4'd7,  1'b0, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_GET,    16'h7FFF, 4'd8,  1'b0, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_GET,    16'h0000, 4'd1,  1'b0, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_LOCK,   16'h1234, 4'd14, 1'b0, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_UNLOCK, 16'h0000, 4'd14, 1'b0, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_UNLOCK, 16'h0000, 4'd14, 1'b0, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_PUT,    16'h0000, 4'd14, 1'b0, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_PUT,    16'h0000, 4'd14, 1'b0, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_PUT,    16'h0000, 4'd14, 1'b0, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_PUT,    16'h0000, 4'd14, 1'b0, 4'd0,  1'b0, STAT_OK));
    dir_rows.push_back(dir_row(ACT_GET,    16'hAAAA, 4'd10, 1'b0, 4'd0,  1'b0, STAT_OK));

    // Synchronous reset, then start driving on a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      maybe_idle();
      send(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part: well-formed sequences with random content, plus some noise.
    hammer_key();
    hammers = 1;
    while (items_sent < ITEMS) begin
      idle_on = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        // Mixed traffic over a small key pool so gets hit often.
        repeat (12) send_rand(2'($urandom_range(0, 3)), pick_key(),
                              4'($urandom_range(0, 15)));
      end else if (pick <= 5) begin
        // Claim fresh keys until the table runs full.
        repeat (20) send_rand(ACT_GET, 16'($urandom_range(0, 65535)),
                              4'($urandom_range(0, 15)));
      end else if (pick == 6) begin
        // Release references across the table, past zero at times.
        for (int s = 0; s < SLOTS; s++) begin
          repeat ($urandom_range(1, 3)) send_rand(ACT_PUT, pick_key(), 4'(s));
        end
      end else if (pick == 7) begin
        // Lock and unlock traffic on random slots.
        repeat (8) send_rand($urandom_range(0, 1) ? ACT_LOCK : ACT_UNLOCK, pick_key(),
                             4'($urandom_range(0, 15)));
      end else if (pick == 8 && hammers < 2 && items_sent < ITEMS - 300) begin
        hammer_key();
        hammers++;
      end else begin
        // Unshaped noise over every field.
        repeat (10) send_rand(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                              4'($urandom_range(0, 15)));
      end
    end

    // Let every outstanding result arrive, then watch for strays.
    start <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rhc_pkg.sv
rtl/rhc_ram.sv
rtl/refcounted_handle_cache.sv
tb/refcounted_handle_cache_test.sv
